FILE: hw/rtl/bhip_pkg.sv
package bhip_pkg;

  // Parser phases, one per section of the bitstream header.
  typedef enum logic [3:0] {
    PH_TAG0    = 4'd0,
    PH_TAG1    = 4'd1,
    PH_COMMENT = 4'd2,
    PH_SEARCH  = 4'd3,
    PH_DUMMY   = 4'd4,
    PH_CMD1    = 4'd5,
    PH_SKIP1   = 4'd6,
    PH_CMD2    = 4'd7,
    PH_SKIP2   = 4'd8,
    PH_ID      = 4'd9,
    PH_DONE    = 4'd10
  } phase_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOPRE     = 3'd1,
    ST_ENCRYPTED = 3'd2,
    ST_BADDUMMY  = 3'd3,
    ST_NORST     = 3'd4,
    ST_NOVFY     = 3'd5,
    ST_TRUNC     = 3'd6
  } status_t;

  localparam logic [31:0] PRE_MASK     = 32'hFFFF_F0FF;
  localparam logic [31:0] PRE_PATTERN  = 32'hFFFF_B0B3;
  localparam logic [31:0] PRE_STANDARD = 32'hFFFF_BDB3;
  localparam logic [15:0] TAG_START    = 16'hFF00;
  localparam logic [15:0] TAG_END      = 16'h00FF;
  localparam logic [31:0] DUMMY_WORD   = 32'hFFFF_FFFF;
  localparam logic [7:0]  CMD_RST_CRC  = 8'h3B;
  localparam logic [7:0]  CMD_VFY_ID   = 8'hE2;

endpackage

FILE: hw/rtl/bitstream_header_id_parser.sv
// Results are registered in the output register, or in the skid register when that is full.
// One byte per cycle while in_stall is low; the state update is a single pass of logic per byte.
// A two-entry output buffer (result register plus skid register) decouples the sides, so
// in_stall rises only when both entries hold results that the consumer has not yet taken.
// Reset (rst, synchronous, active high) returns the parser to the first tag byte and empties
// the output buffer; parser state also returns to reset after every byte marked last.
module bitstream_header_id_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                last,
  output logic                out_valid,
  input  logic                out_stall,
  output bhip_pkg::status_t   status,
  output logic [31:0]         device_id,
  output logic                comment_seen
);
  import bhip_pkg::*;

  // Parser state registers.
  phase_t      phase, phase_next;
  logic [31:0] preamble_window, preamble_window_next;
  logic [15:0] end_tag_window, end_tag_window_next;
  logic [1:0]  byte_count, byte_count_next;
  logic [31:0] id_accumulator, id_accumulator_next;
  logic        comment_flag, comment_flag_next;

  // Skid register behind the output register.
  logic        skid_valid;
  status_t     skid_status;
  logic [31:0] skid_id;
  logic        skid_comment;

  // Result of the byte being transferred this cycle.
  logic        res_valid;
  status_t     res_status;
  logic [31:0] res_id;
  logic        res_comment;

  // Phase after this byte, before the end-of-stream return to reset.
  phase_t      phase_adv;

  logic [31:0] win_shift;
  logic [31:0] acc_shift;
  logic [15:0] tag_pair;
  logic [15:0] end_shift;

  logic accept;
  logic pop;

  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;
  // The input side stalls only when both buffer entries are occupied.
  assign in_stall = skid_valid;

  assign win_shift = {preamble_window[23:0], data_byte};
  assign acc_shift = {id_accumulator[23:0], data_byte};
  assign tag_pair  = {preamble_window[7:0], data_byte};
  assign end_shift = {end_tag_window[7:0], data_byte};

  always_comb begin
    phase_adv            = phase;
    preamble_window_next = preamble_window;
    end_tag_window_next  = end_tag_window;
    byte_count_next      = byte_count;
    id_accumulator_next  = id_accumulator;
    comment_flag_next    = comment_flag;
    res_valid            = 1'b0;
    res_status           = ST_OK;
    res_id               = 32'd0;

    case (phase)
      PH_TAG0: begin
        preamble_window_next = {24'd0, data_byte};
        phase_adv            = PH_TAG1;
      end
      PH_TAG1: begin
        if (tag_pair == TAG_START) begin
          // A leading comment block starts here; its end-tag window begins empty.
          comment_flag_next    = 1'b1;
          end_tag_window_next  = 16'd0;
          preamble_window_next = 32'd0;
          phase_adv            = PH_COMMENT;
        end else begin
          // No comment: the two bytes seed the preamble search.
          preamble_window_next = {16'd0, tag_pair};
          phase_adv            = PH_SEARCH;
        end
      end
      PH_COMMENT: begin
        end_tag_window_next = end_shift;
        if (end_shift == TAG_END) begin
          preamble_window_next = 32'd0;
          phase_adv            = PH_SEARCH;
        end
      end
      PH_SEARCH: begin
        preamble_window_next = win_shift;
        if ((win_shift & PRE_MASK) == PRE_PATTERN) begin
          if (win_shift == PRE_STANDARD) begin
            byte_count_next     = 2'd0;
            id_accumulator_next = 32'd0;
            phase_adv           = PH_DUMMY;
          end else begin
            // Any other preamble variant marks an encrypted bitstream.
            res_valid  = 1'b1;
            res_status = ST_ENCRYPTED;
          end
        end
      end
      PH_DUMMY, PH_ID: begin
        id_accumulator_next = acc_shift;
        byte_count_next     = byte_count + 2'd1;
        if (byte_count == 2'd3) begin
          if (phase == PH_ID) begin
            res_valid  = 1'b1;
            res_status = ST_OK;
            res_id     = acc_shift;
          end else if (acc_shift == DUMMY_WORD) begin
            phase_adv = PH_CMD1;
          end else begin
            res_valid  = 1'b1;
            res_status = ST_BADDUMMY;
          end
        end
      end
      PH_CMD1: begin
        if (data_byte == CMD_RST_CRC) begin
          byte_count_next = 2'd0;
          phase_adv       = PH_SKIP1;
        end else begin
          res_valid  = 1'b1;
          res_status = ST_NORST;
        end
      end
      PH_CMD2: begin
        if (data_byte == CMD_VFY_ID) begin
          byte_count_next = 2'd0;
          phase_adv       = PH_SKIP2;
        end else begin
          res_valid  = 1'b1;
          res_status = ST_NOVFY;
        end
      end
      PH_SKIP1, PH_SKIP2: begin
        // Each command is followed by three bytes that are not examined.
        if (byte_count == 2'd2) begin
          byte_count_next     = 2'd0;
          id_accumulator_next = 32'd0;
          phase_adv           = (phase == PH_SKIP1) ? PH_CMD2 : PH_ID;
        end else begin
          byte_count_next = byte_count + 2'd1;
        end
      end
      default: begin
        // The parse has already reported; bytes are ignored until the stream ends.
      end
    endcase

    if (res_valid) begin
      phase_adv = PH_DONE;
    end

    res_comment = comment_flag_next;
    phase_next  = phase_adv;

    if (last) begin
      // The stream ends here. If nothing has been reported yet, report why the
      // header was cut short: still looking for the preamble, or truncated after it.
      if (!res_valid && phase != PH_DONE) begin
        res_valid = 1'b1;
        if (phase_adv == PH_TAG1 || phase_adv == PH_COMMENT || phase_adv == PH_SEARCH) begin
          res_status = ST_NOPRE;
        end else begin
          res_status = ST_TRUNC;
        end
      end
      phase_next           = PH_TAG0;
      preamble_window_next = 32'd0;
      end_tag_window_next  = 16'd0;
      byte_count_next      = 2'd0;
      id_accumulator_next  = 32'd0;
      comment_flag_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_TAG0;
      preamble_window <= 32'd0;
      end_tag_window  <= 16'd0;
      byte_count      <= 2'd0;
      id_accumulator  <= 32'd0;
      comment_flag    <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      preamble_window <= preamble_window_next;
      end_tag_window  <= end_tag_window_next;
      byte_count      <= byte_count_next;
      id_accumulator  <= id_accumulator_next;
      comment_flag    <= comment_flag_next;
    end
  end

  // Output register and skid register. A new result goes to the output register
  // when it is free or being emptied this cycle, otherwise to the skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept && res_valid) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        status       <= skid_status;
        device_id    <= skid_id;
        comment_seen <= skid_comment;
      end
    end else if (accept && res_valid) begin
      if (!out_valid || pop) begin
        status       <= res_status;
        device_id    <= res_id;
        comment_seen <= res_comment;
      end else begin
        skid_status  <= res_status;
        skid_id      <= res_id;
        skid_comment <= res_comment;
      end
    end
  end

  // The skid register is only ever filled behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the output register is empty");

  // Failure results never carry a device ID.
  a_id_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> device_id == 32'd0)
    else $error("device_id is nonzero on a failed parse");

  // The byte that ends a stream returns the parser to the first tag byte.
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> phase == PH_TAG0 && !comment_flag)
    else $error("parser did not restart after the final byte");

  // The comment flag can only be set once the tag bytes are behind the parser.
  a_comment_after_tag: assert property (@(posedge clk) disable iff (rst)
    comment_flag |-> phase != PH_TAG0 && phase != PH_TAG1)
    else $error("comment flag set while still in the tag bytes");

endmodule
